/* design/isort_pkg.sv */
`timescale 1ns / 1ps
// Shared types for the insertion sorter: request and result payload structs,
// plus the command/status structs between controller and datapath. No dependencies.
package isort_pkg;

	localparam int DATA_W = 32;

	// One request: a list element and its end-of-list mark
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	// One result: next element in ascending order and its flags
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
		logic                     dropped;
	} result_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic insert;   // place the request value into the sorted row
		logic shift;    // emit entry 0 and move the row down one place
	} isort_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic full;     // row holds its full capacity
		logic one_left; // exactly one entry stored
	} isort_stat_t;

endpackage

/* design/isort_datapath.sv */
`timescale 1ns / 1ps
// Sorted row of compare-and-shift cells with its fill count.
// Depends on isort_pkg.
module isort_datapath import isort_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  isort_cmd_t               cmd,
	input  logic signed [DATA_W-1:0] value,
	output isort_stat_t              stat,
	output logic signed [DATA_W-1:0] head
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic signed [DATA_W-1:0] store_q [CAPACITY];
	logic [CNT_W-1:0]         cnt_q;
	logic [CAPACITY-1:0]      gt;

	// Each cell compares against the new value; valid cells form a sorted prefix
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign gt[i] = (CNT_W'(i) < cnt_q) && (store_q[i] > value);

		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				if (cmd.shift) begin
					store_q[i] <= store_q[i+1];
				end else if (cmd.insert && (gt[i] || cnt_q == CNT_W'(i))) begin
					store_q[i] <= value;
				end
			end
		end else if (i == CAPACITY - 1) begin : g_top
			always_ff @(posedge clk) begin
				if (cmd.shift) begin
					store_q[i] <= store_q[i];
				end else if (cmd.insert && gt[i-1]) begin
					store_q[i] <= store_q[i-1];
				end else if (cmd.insert && (gt[i] || cnt_q == CNT_W'(i))) begin
					store_q[i] <= value;
				end
			end
		end else begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.shift) begin
					store_q[i] <= store_q[i+1];
				end else if (cmd.insert && gt[i-1]) begin
					store_q[i] <= store_q[i-1];
				end else if (cmd.insert && (gt[i] || cnt_q == CNT_W'(i))) begin
					store_q[i] <= value;
				end
			end
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.shift) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end else if (cmd.insert) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	assign stat.full     = (cnt_q == CNT_W'(CAPACITY));
	assign stat.one_left = (cnt_q == CNT_W'(1));
	assign head          = store_q[0];

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("fill count beyond capacity");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift |-> cnt_q != '0)
		else $error("drain shift on empty row");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |-> !stat.full && !cmd.shift)
		else $error("insert into full row or during drain");

	a_sorted_head: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= CNT_W'(2) |-> store_q[0] <= store_q[1])
		else $error("row head out of order");
`endif

endmodule

/* design/isort_ctrl.sv */
`timescale 1ns / 1ps
// Controller for the insertion sorter: accept/drain state machine and overflow flag.
// Depends on isort_pkg.
module isort_ctrl import isort_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        last,
	input  isort_stat_t stat,
	output isort_cmd_t  cmd,
	output logic        busy,
	output logic        strobe,
	output logic        final_res,
	output logic        dropped
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic state_q;
	logic ovf_q;
	logic accept;

	assign accept = start && (state_q == ST_IDLE);

	// Commands to the row
	assign cmd.insert = accept && !stat.full;
	assign cmd.shift  = (state_q == ST_DRAIN);

	// State and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ovf_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (stat.full) ovf_q <= 1'b1;
						if (last) state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (stat.one_left) begin
						state_q <= ST_IDLE;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q == ST_DRAIN);
	assign strobe    = (state_q == ST_DRAIN);
	assign final_res = (state_q == ST_DRAIN) && stat.one_left;
	assign dropped   = ovf_q;

`ifndef ASSERT_OFF
	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && stat.one_left |=> state_q == ST_IDLE && !ovf_q)
		else $error("drain did not end after last entry");

	a_full_sets_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && stat.full && !last |=> ovf_q)
		else $error("overflow not recorded");

	a_drain_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) && !stat.one_left |=> state_q == ST_DRAIN)
		else $error("drain left early");
`endif

endmodule

/* design/insertion_sorter_core.sv */
`timescale 1ns / 1ps
// Top level of the insertion sorter: controller plus sorted-row datapath.
// Depends on isort_pkg, isort_ctrl, isort_datapath.

// A request not marked last is compared against every stored entry at
// once and slotted into the sorted row, so busy stays low and a request
// may follow every cycle. A request marked last raises busy while the row
// drains through its head cell, one result per cycle with strobe high and
// one result for each stored entry (1 to CAPACITY), in ascending order,
// the final one with final_res set. Results are shown for one cycle each
// and cannot be stalled. Once the row holds CAPACITY entries, further
// values of the list are dropped and every result of that list carries
// dropped.
module insertion_sorter_core import isort_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  item_t   item,
	output logic    strobe,
	output result_t result
);

	isort_cmd_t               cmd;
	isort_stat_t              stat;
	logic signed [DATA_W-1:0] head;
	logic                     final_res;
	logic                     dropped;

	isort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last      (item.last),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy),
		.strobe    (strobe),
		.final_res (final_res),
		.dropped   (dropped)
	);

	isort_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (item.value),
		.stat   (stat),
		.head   (head)
	);

	// Result payload
	assign result.sorted_value = head;
	assign result.final_res    = final_res;
	assign result.dropped      = dropped;

endmodule
